>>> design/psft_pkg.sv
`default_nettype none

package psft_pkg;

  localparam int SeqWordW  = 32;
  localparam int SeqW      = 31;
  localparam int FragW     = 16;
  localparam int AvailW    = 11;
  localparam int VerdictW  = 3;
  localparam int OutLenW   = 15;
  localparam int CfgW      = 16;

  localparam logic [CfgW-1:0] MaxMsgBytesReset = 16'd16384;
  localparam int BufferBytesDefault    = 16384;
  localparam int FullFragBytesDefault  = 1300;
  localparam int MsgHdrBytes           = 4;

  typedef enum logic [VerdictW-1:0] {
    VerdictWhole      = 3'd0,
    VerdictMsgReady   = 3'd1,
    VerdictOutOfOrder = 3'd2,
    VerdictGap        = 3'd3,
    VerdictIllegalLen = 3'd4,
    VerdictStored     = 3'd5,
    VerdictTooLarge   = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [SeqWordW-1:0]     sequence_word;
    logic signed [FragW-1:0] frag_start;
    logic signed [FragW-1:0] frag_length;
    logic [AvailW-1:0]       payload_available;
  } in_word_t;

  typedef struct packed {
    verdict_e             verdict;
    logic [SeqW-1:0]      dropped_count;
    logic [OutLenW-1:0]   copy_offset;
    logic [OutLenW-1:0]   message_length;
  } out_word_t;

endpackage

`default_nettype wire

>>> design/psft_in_if.sv
`default_nettype none

interface psft_in_if;
  import psft_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SeqWordW-1:0]     sequence_word;
  logic signed [FragW-1:0] frag_start;
  logic signed [FragW-1:0] frag_length;
  logic [AvailW-1:0]       payload_available;

  modport source (
    output valid, sequence_word, frag_start, frag_length, payload_available,
    input  ready
  );

  modport sink (
    input  valid, sequence_word, frag_start, frag_length, payload_available,
    output ready
  );
endinterface

`default_nettype wire

>>> design/psft_out_if.sv
`default_nettype none

interface psft_out_if;
  import psft_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VerdictW-1:0]  verdict;
  logic [SeqW-1:0]      dropped_count;
  logic [OutLenW-1:0]   copy_offset;
  logic [OutLenW-1:0]   message_length;

  modport source (
    output valid, verdict, dropped_count, copy_offset, message_length,
    input  ready
  );

  modport sink (
    input  valid, verdict, dropped_count, copy_offset, message_length,
    output ready
  );
endinterface

`default_nettype wire

>>> design/psft_in_stage.sv
`default_nettype none

module psft_in_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire psft_pkg::in_word_t in_word_i,
  input  wire logic             advance_i,
  output logic                  valid_o,
  output psft_pkg::in_word_t    word_o
);
  import psft_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     load;

  // slot frees up in the same cycle its word moves on
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

>>> design/psft_tracker.sv
`default_nettype none

module psft_tracker #(
  parameter int BUFFER_BYTES        = psft_pkg::BufferBytesDefault,
  parameter int FULL_FRAGMENT_BYTES = psft_pkg::FullFragBytesDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [psft_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic                    step_i,
  input  wire psft_pkg::in_word_t      word_i,
  output psft_pkg::out_word_t          result_o
);
  import psft_pkg::*;

  localparam int FillW = $clog2(BUFFER_BYTES + 1);
  localparam int LenW  = FragW - 1;
  localparam int SumW  = ((FillW > LenW) ? FillW : LenW) + 1;
  localparam logic [SumW-1:0] BufLimit = SumW'(BUFFER_BYTES);
  localparam logic [LenW-1:0] FullLen  = LenW'(FULL_FRAGMENT_BYTES);
  localparam logic [SumW-1:0] HdrBytes = SumW'(MsgHdrBytes);

  logic [CfgW-1:0]  max_bytes_q;
  logic [SeqW-1:0]  last_seq_q, last_seq_d;
  logic [SeqW-1:0]  frag_seq_q, frag_seq_d;
  logic [FillW-1:0] fill_q, fill_d;

  logic [SeqW-1:0]  seq;
  logic             is_frag;
  logic [FillW-1:0] fill_base;
  logic [LenW-1:0]  len_u;
  logic             start_ok;
  logic             len_bad;
  logic [SumW-1:0]  sum;
  logic             too_large;
  out_word_t        res;

  assign seq       = word_i.sequence_word[SeqW-1:0];
  assign is_frag   = word_i.sequence_word[SeqWordW-1];
  // a new fragment sequence restarts the fill before the start check
  assign fill_base = (seq != frag_seq_q) ? '0 : fill_q;
  assign len_u     = word_i.frag_length[LenW-1:0];
  assign start_ok  = !word_i.frag_start[FragW-1] &&
                     (SumW'(word_i.frag_start[LenW-1:0]) == SumW'(fill_base));
  assign sum       = SumW'(fill_base) + SumW'(len_u);
  assign len_bad   = word_i.frag_length[FragW-1] ||
                     (len_u > LenW'(word_i.payload_available)) ||
                     (sum > BufLimit);
  assign too_large = 32'(sum) > 32'(max_bytes_q);

  always_comb begin
    res         = '0;
    res.verdict = VerdictOutOfOrder;
    last_seq_d  = last_seq_q;
    frag_seq_d  = frag_seq_q;
    fill_d      = fill_q;
    if (seq > last_seq_q) begin
      res.dropped_count = seq - last_seq_q - SeqW'(1);
      if (!is_frag) begin
        res.verdict = VerdictWhole;
        last_seq_d  = seq;
      end else begin
        frag_seq_d = seq;
        fill_d     = fill_base;
        if (!start_ok) begin
          res.verdict = VerdictGap;
        end else if (len_bad) begin
          res.verdict = VerdictIllegalLen;
        end else begin
          res.copy_offset = OutLenW'(fill_base);
          fill_d          = sum[FillW-1:0];
          if (len_u == FullLen) begin
            res.verdict = VerdictStored;
          end else if (too_large) begin
            // fill is kept, sequence not advanced
            res.verdict = VerdictTooLarge;
          end else begin
            res.verdict        = VerdictMsgReady;
            res.message_length = OutLenW'(sum + HdrBytes);
            fill_d             = '0;
            last_seq_d         = seq;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxMsgBytesReset;
      last_seq_q  <= '0;
      frag_seq_q  <= '0;
      fill_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_wdata_i;
      end
      if (step_i) begin
        last_seq_q <= last_seq_d;
        frag_seq_q <= frag_seq_d;
        fill_q     <= fill_d;
      end
    end
  end

  assign result_o = res;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= BUFFER_BYTES)
    else $error("fill beyond buffer size");

  a_ready_clears_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.verdict == VerdictMsgReady) |=> (fill_q == '0))
    else $error("fill not cleared after delivered message");

  a_ooo_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.verdict == VerdictOutOfOrder) |=>
      $stable(last_seq_q) && $stable(frag_seq_q) && $stable(fill_q))
    else $error("state changed on out-of-order word");

endmodule

`default_nettype wire

>>> design/packet_sequence_fragment_tracker.sv
`default_nettype none

// Packet sequence and fragment tracker.
// in_i carries one received packet header per word: raw sequence word (bit 31
// is the fragment flag), fragment start and length, payload bytes available.
// out_o returns exactly one verdict word per header: verdict, dropped packet
// count, buffer copy offset and, for a finished message, its length.
// cfg_we_i/cfg_wdata_i write the largest deliverable message size; write it
// only while no header is in flight.
// A header is held in the input register, then its verdict in the result register.
// Throughput: one header per cycle while out_o is not stalled; the decision is
// a single pass of compares and adds on the tracked state between the two.
// Reset clears the last sequence, fragment sequence and fill, sets the size
// limit to 16384 and empties both registers.
// When out_o is stalled the result register holds and one more header waits
// in the input register; in_i.ready drops only when both are full.
module packet_sequence_fragment_tracker #(
  parameter int BUFFER_BYTES        = psft_pkg::BufferBytesDefault,
  parameter int FULL_FRAGMENT_BYTES = psft_pkg::FullFragBytesDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [psft_pkg::CfgW-1:0] cfg_wdata_i,
  psft_in_if.sink                        in_i,
  psft_out_if.source                     out_o
);
  import psft_pkg::*;

  in_word_t  in_word;
  in_word_t  cur_word;
  logic      cur_valid;
  logic      advance;
  out_word_t result;
  out_word_t out_q;
  logic      out_valid_q, out_valid_d;

  assign in_word.sequence_word     = in_i.sequence_word;
  assign in_word.frag_start        = in_i.frag_start;
  assign in_word.frag_length       = in_i.frag_length;
  assign in_word.payload_available = in_i.payload_available;

  assign advance = cur_valid && (!out_valid_q || out_o.ready);

  psft_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_word_i  (in_word),
    .advance_i  (advance),
    .valid_o    (cur_valid),
    .word_o     (cur_word)
  );

  psft_tracker #(
    .BUFFER_BYTES        (BUFFER_BYTES),
    .FULL_FRAGMENT_BYTES (FULL_FRAGMENT_BYTES)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .word_i      (cur_word),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.verdict        = out_q.verdict;
  assign out_o.dropped_count  = out_q.dropped_count;
  assign out_o.copy_offset    = out_q.copy_offset;
  assign out_o.message_length = out_q.message_length;

endmodule

`default_nettype wire

>>> tb/sv/tb_packet_sequence_fragment_tracker.sv
`default_nettype none

module tb_packet_sequence_fragment_tracker;
  import psft_pkg::*;

  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  psft_in_if  hdr_if ();
  psft_out_if verdict_if ();

  packet_sequence_fragment_tracker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (hdr_if),
    .out_o       (verdict_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // tracker state as the testbench sees it
  logic [SeqW-1:0] trk_last_seq = '0;
  logic [SeqW-1:0] trk_frag_seq = '0;
  int              trk_fill = 0;
  logic [CfgW-1:0] trk_max_bytes = MaxMsgBytesReset;

  in_word_t  pending_headers[$];
  out_word_t expected_verdicts[$];
  in_word_t  bus_hdr;
  int        src_idle_pct = 0;
  int        sink_idle_pct = 0;
  int        fail_count = 0;
  int        cycle_count = 0;
  int unsigned next_seq = 0;

  function automatic out_word_t track_header(input in_word_t h);
    out_word_t r;
    logic [SeqW-1:0] seq;
    int start_v;
    int len_v;
    r = '0;
    r.verdict = VerdictOutOfOrder;
    seq = h.sequence_word[SeqW-1:0];
    start_v = $signed(h.frag_start);
    len_v = $signed(h.frag_length);
    if (seq <= trk_last_seq) return r;
    r.dropped_count = seq - trk_last_seq - 1'b1;
    if (!h.sequence_word[SeqWordW-1]) begin
      trk_last_seq = seq;
      r.verdict = VerdictWhole;
      return r;
    end
    // a new fragment sequence restarts the fill, even if the word is rejected below
    if (seq != trk_frag_seq) begin
      trk_frag_seq = seq;
      trk_fill = 0;
    end
    if (start_v != trk_fill) begin
      r.verdict = VerdictGap;
      return r;
    end
    if (len_v < 0 || len_v > int'(h.payload_available) ||
        trk_fill + len_v > BufferBytesDefault) begin
      r.verdict = VerdictIllegalLen;
      return r;
    end
    r.copy_offset = OutLenW'(trk_fill);
    trk_fill += len_v;
    if (len_v == FullFragBytesDefault) begin
      r.verdict = VerdictStored;
    end else if (trk_fill > int'(trk_max_bytes)) begin
      r.verdict = VerdictTooLarge;  // fill is kept
    end else begin
      r.verdict = VerdictMsgReady;
      r.message_length = OutLenW'(trk_fill + MsgHdrBytes);
      trk_fill = 0;
      trk_last_seq = seq;
    end
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void push_hdr(input logic [SeqWordW-1:0] w, input logic [FragW-1:0] s,
                                   input logic [FragW-1:0] l, input logic [AvailW-1:0] a);
    in_word_t h;
    h.sequence_word = w;
    h.frag_start = s;
    h.frag_length = l;
    h.payload_available = a;
    pending_headers.push_back(h);
  endfunction

  // driver: predicts each accepted header, then presents the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hdr_if.valid <= 1'b0;
    end else begin
      if (hdr_if.valid && hdr_if.ready) expected_verdicts.push_back(track_header(bus_hdr));
      if (!hdr_if.valid || hdr_if.ready) begin
        if (pending_headers.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          bus_hdr = pending_headers.pop_front();
          hdr_if.valid <= 1'b1;
          hdr_if.sequence_word <= bus_hdr.sequence_word;
          hdr_if.frag_start <= bus_hdr.frag_start;
          hdr_if.frag_length <= bus_hdr.frag_length;
          hdr_if.payload_available <= bus_hdr.payload_available;
        end else begin
          hdr_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (!rst_ni) begin
      verdict_if.ready <= 1'b0;
    end else begin
      if (verdict_if.valid && verdict_if.ready) begin
        got.verdict = verdict_e'(verdict_if.verdict);
        got.dropped_count = verdict_if.dropped_count;
        got.copy_offset = verdict_if.copy_offset;
        got.message_length = verdict_if.message_length;
        if (expected_verdicts.size() == 0) begin
          note_failure($sformatf("unexpected word: verdict %0d dropped %0d offset %0d len %0d",
                                 got.verdict, got.dropped_count, got.copy_offset,
                                 got.message_length));
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want)
            note_failure($sformatf({"mismatch (exp/got): verdict %0d/%0d dropped %0d/%0d ",
                                    "offset %0d/%0d len %0d/%0d"},
                                   want.verdict, got.verdict, want.dropped_count,
                                   got.dropped_count, want.copy_offset, got.copy_offset,
                                   want.message_length, got.message_length));
        end
      end
      verdict_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk_i);
    while (pending_headers.size() != 0 || hdr_if.valid || expected_verdicts.size() != 0);
  endtask

  task automatic write_max_bytes(input logic [CfgW-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    trk_max_bytes = v;
    @(negedge clk_i);
  endtask

  // mostly well-formed fragment runs, plus whole packets, stale sequences and junk
  task automatic queue_traffic(input int n_items, input bit wide_jumps);
    logic [SeqWordW-1:0] w;
    logic [FragW-1:0] start_v;
    logic [FragW-1:0] len_v;
    logic [AvailW-1:0] avail_v;
    int unsigned nfull;
    int unsigned k;
    int pick;
    int made;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      if (wide_jumps && pick < 3) next_seq += $urandom_range(1 << 16, 1 << 24);
      if (pick < 20) begin
        next_seq += 1 + $urandom_range(2);
        w = {1'b0, next_seq[SeqW-1:0]};
        push_hdr(w, 16'($urandom), 16'($urandom), 11'($urandom));
        made++;
      end else if (pick < 32) begin
        w = $urandom;
        w[SeqW-1:0] = SeqW'($urandom_range(next_seq));
        push_hdr(w, 16'($urandom), 16'($urandom), 11'($urandom));
        made++;
      end else if (pick < 38) begin
        next_seq += 1;
        w = {1'b1, next_seq[SeqW-1:0]};
        push_hdr(w, 16'($urandom), 16'($urandom), 11'($urandom));
        made++;
      end else begin
        next_seq += 1 + (($urandom_range(9) == 0) ? $urandom_range(20) : 0);
        w = {1'b1, next_seq[SeqW-1:0]};
        nfull = ($urandom_range(11) == 0) ? $urandom_range(11, 12) : $urandom_range(3);
        for (k = 0; k <= nfull; k++) begin
          start_v = 16'(k * FullFragBytesDefault);
          len_v = (k < nfull) ? 16'(FullFragBytesDefault)
                              : 16'($urandom_range(FullFragBytesDefault - 1));
          avail_v = ($urandom_range(3) == 0) ? 11'(len_v) : 11'($urandom_range(2047, len_v));
          if ($urandom_range(19) == 0) begin
            case ($urandom_range(2))
              0: start_v = start_v + 16'(1 + $urandom_range(1));
              1: len_v = 16'h8000 | 16'($urandom);
              default: avail_v = 11'(len_v) - 11'd1;
            endcase
          end
          push_hdr(w, start_v, len_v, avail_v);
          made++;
        end
        // resend the tail, which is stale once it has delivered the message
        if ($urandom_range(9) == 0) begin
          push_hdr(w, start_v, len_v, avail_v);
          made++;
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    hdr_if.valid = 1'b0;
    hdr_if.sequence_word = '0;
    hdr_if.frag_start = '0;
    hdr_if.frag_length = '0;
    hdr_if.payload_available = '0;
    verdict_if.ready = 1'b0;
    src_idle_pct = 11;
    sink_idle_pct = 52;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_hdr(32'h0000_0000, 16'h0000, 16'h0000, 11'd0);     // not above reset sequence
    push_hdr(32'h0000_0001, 16'h7FFF, 16'h8000, 11'd2047);  // whole word, rest ignored
    push_hdr(32'h0000_0001, 16'h0000, 16'h0000, 11'd0);     // duplicate
    push_hdr(32'h0000_0005, 16'h0000, 16'h0000, 11'd0);     // three dropped
    push_hdr(32'h8000_0006, 16'd0, 16'd100, 11'd100);
    push_hdr(32'h8000_0007, 16'd0, 16'd1300, 11'd1300);
    push_hdr(32'h8000_0007, 16'd0, 16'd10, 11'd2047);       // gap, fill kept
    push_hdr(32'h8000_0007, 16'd1300, 16'hFFFF, 11'd2047);  // negative length
    push_hdr(32'h8000_0007, 16'd1300, 16'd200, 11'd199);    // beyond payload
    push_hdr(32'h8000_0007, 16'd1300, 16'd0, 11'd0);        // empty tail delivers
    push_hdr(32'h8000_0008, 16'h8000, 16'd0, 11'd0);        // negative start
    push_hdr(32'h8000_0008, 16'h7FFF, 16'd5, 11'd5);
    push_hdr(32'h8000_0009, 16'd0, 16'd1300, 11'd2047);
    push_hdr(32'h8000_000A, 16'd0, 16'd40, 11'd40);         // sequence switch drops fill
    push_hdr(32'h8000_000B, 16'd0, 16'hFFFB, 11'd100);      // illegal, switch still kept
    push_hdr(32'h8000_000B, 16'd0, 16'h7FFF, 11'd2047);
    push_hdr(32'h8000_000B, 16'd0, 16'd30, 11'd2047);
    push_hdr(32'h0000_000B, 16'd0, 16'd0, 11'd0);           // stale whole word

    write_max_bytes('0);
    push_hdr(32'h8000_000C, 16'd0, 16'd10, 11'd10);         // too large, fill kept
    push_hdr(32'h8000_000C, 16'd10, 16'd5, 11'd5);
    push_hdr(32'h8000_000C, 16'd15, 16'd1300, 11'd1300);    // full fragment wins
    queue_traffic(300, 1'b0);

    write_max_bytes(16'hFFFF);
    src_idle_pct = 52;
    sink_idle_pct = 11;
    queue_traffic(300, 1'b0);

    write_max_bytes(16'($urandom_range(1000, 8000)));
    src_idle_pct = 0;
    sink_idle_pct = 0;
    queue_traffic(330, 1'b1);
    push_hdr(32'hFFFF_FFFF, 16'd0, 16'd20, 11'd2047);       // top sequence
    repeat (5) push_hdr($urandom, 16'($urandom), 16'($urandom), 11'($urandom));

    drain();
    repeat (8) @(posedge clk_i);
    if (expected_verdicts.size() != 0) note_failure("words still expected at end");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/psft_pkg.sv
design/psft_in_if.sv
design/psft_out_if.sv
design/psft_in_stage.sv
design/psft_tracker.sv
design/packet_sequence_fragment_tracker.sv
tb/sv/tb_packet_sequence_fragment_tracker.sv
